### rtl/core/wlbp_pkg.sv
`timescale 1ns / 1ps
package wlbp_pkg;
  localparam int WEIGHT_W = 32;
  localparam int SCORE_W  = 40;
  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;
  localparam logic [0:0] CFG_SINGLE_WEIGHT = 1'b0;
  localparam logic [0:0] CFG_MAX_WORD_LEN  = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_DISC  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [5:0] edge_begin;
    logic [6:0] edge_end;
    logic [31:0] edge_weight;
    logic [6:0] char_count;
  } in_req_t;

  typedef struct packed {
    logic [5:0] seg_begin;
    logic [6:0] seg_end;
    logic       status;
    logic       last;
  } out_req_t;
endpackage

### rtl/core/wlbp_if.sv
`timescale 1ns / 1ps
interface wlbp_in_if import wlbp_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wlbp_out_if import wlbp_pkg::*; ();
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/word_lattice_best_path.sv
`timescale 1ns / 1ps
// Edge request: accepted in idle, then read and compare-write states before the next request
// is taken; a dropped edge frees the input on the next cycle. Solve: read, compare and write
// states for each reachable (position, span) pair in the text, a read to leave each position,
// a push per backtrack segment, then each result is read back and sent, waiting while output
// stalls. Every solve ends with a clearing pass over all MAX_CHARS x MAX_SPAN (512) entries.
// Reset (synchronous, rst_n low) starts the same clearing pass; input ready stays low.
module word_lattice_best_path
  import wlbp_pkg::*;
#(
  parameter int MAX_CHARS = 64,
  parameter int MAX_SPAN  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  wlbp_in_if.sink     in_ch,
  wlbp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int POSW  = $clog2(MAX_CHARS + 1);
  localparam int BW    = $clog2(MAX_CHARS);
  localparam int DEPTH = MAX_CHARS * MAX_SPAN;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERD   = 4'd1;
  localparam logic [3:0] S_EWR   = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_FCMP  = 4'd4;
  localparam logic [3:0] S_FWR   = 4'd5;
  localparam logic [3:0] S_BRD   = 4'd6;
  localparam logic [3:0] S_BPUSH = 4'd7;
  localparam logic [3:0] S_ORD   = 4'd8;
  localparam logic [3:0] S_OBEG  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [31:0] single_w_r;
  logic [3:0]  max_len_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_w_r <= '0;
      max_len_r  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SINGLE_WEIGHT: single_w_r <= cfg_data;
        CFG_MAX_WORD_LEN:  max_len_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective span limit in 5 bits.
  logic [4:0] lim;
  always_comb begin
    lim = {1'b0, max_len_r};
    if (lim == 5'd0) lim = 5'd1;
    if (lim > 5'(MAX_SPAN)) lim = 5'(MAX_SPAN);
  end

  // Memories. The edge memory keeps a valid flag above each weight.
  logic [32:0]        ew_mem [DEPTH];
  logic [SCORE_W-1:0] sc_mem [MAX_CHARS+1];
  logic [POSW-1:0]    pr_mem [MAX_CHARS+1];
  logic [MAX_CHARS:0] reach_r;
  logic [POSW-1:0]    stk_mem [MAX_CHARS];

  logic [AW-1:0]        ew_raddr, ew_waddr;
  logic                 ew_we;
  logic [32:0]          ew_wdata, ew_q;
  logic [POSW-1:0]      sc_raddr, sc_waddr;
  logic                 sc_we;
  logic [SCORE_W-1:0]   sc_wdata, sc_q;
  logic [POSW-1:0]      pr_q, pr_wdata;
  logic [BW-1:0]        stk_addr;
  logic                 stk_we;
  logic [POSW-1:0]      stk_q;

  // Working registers.
  in_req_t          req_r;
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    clr_r;
  logic [POSW-1:0]  n_r, b_r, e_r, pos_r;
  logic [4:0]       s_r;
  logic [POSW-1:0]  dep_r, k_r;
  logic [SCORE_W-1:0] cand_r;
  logic             wv_r;
  logic [POSW-1:0]  oend_r;
  out_req_t         out_r;
  logic             out_v_r, out_v_nxt;

  always_ff @(posedge clk) begin
    if (ew_we) ew_mem[ew_waddr] <= ew_wdata;
    ew_q <= ew_mem[ew_raddr];
  end
  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
      pr_mem[sc_waddr] <= pr_wdata;
    end
    sc_q <= sc_mem[sc_raddr];
    pr_q <= pr_mem[sc_raddr];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_addr] <= pos_r;
    stk_q <= stk_mem[stk_addr];
  end

  // Edge request checks.
  logic [7:0] span_w;
  logic       edge_ok;
  assign span_w  = {1'b0, in_ch.data.edge_end} - {2'b0, in_ch.data.edge_begin};
  assign edge_ok = (in_ch.data.edge_end > {1'b0, in_ch.data.edge_begin} + 7'd1) &&
                   ({25'd0, in_ch.data.edge_end} <= 32'(MAX_CHARS)) &&
                   ({26'd0, in_ch.data.edge_begin} < 32'(MAX_CHARS)) &&
                   (span_w <= {3'b0, lim});

  logic [AW-1:0] in_idx;
  assign in_idx = AW'(32'(in_ch.data.edge_begin) * MAX_SPAN + 32'(span_w) - 1);

  logic [POSW-1:0] n_in;
  assign n_in = (32'(in_ch.data.char_count) > 32'(MAX_CHARS)) ? POSW'(MAX_CHARS)
                : POSW'(in_ch.data.char_count);

  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;

  // Forward pass helpers: current (b, s) pair.
  logic [POSW:0]   e_calc;
  logic [AW-1:0]   f_idx;
  logic            f_skip;
  assign e_calc = {1'b0, b_r} + (POSW+1)'(s_r);
  assign f_idx  = AW'(32'(b_r) * MAX_SPAN + 32'(s_r) - 1);
  assign f_skip = !reach_r[b_r] || (e_calc > {1'b0, n_r}) || (s_r > 5'(MAX_SPAN));

  logic [SCORE_W-1:0] wsel;
  assign wsel = (s_r == 5'd1) ? {{(SCORE_W-32){single_w_r[31]}}, single_w_r}
                              : {{(SCORE_W-32){ew_q[31]}}, ew_q[31:0]};

  // Next state and memory port control.
  always_comb begin
    state_nxt = state_r;
    out_v_nxt = out_v_r && !out_ch.ready;
    ew_raddr  = idx_r;
    ew_waddr  = idx_r;
    ew_we     = 1'b0;
    ew_wdata  = {1'b1, req_r.edge_weight};
    sc_raddr  = b_r;
    sc_waddr  = e_r;
    sc_we     = 1'b0;
    sc_wdata  = cand_r;
    pr_wdata  = b_r;
    stk_addr  = BW'(dep_r);
    stk_we    = 1'b0;
    case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_ch.data.req_type == REQ_EDGE) begin
          if (edge_ok) state_nxt = S_ERD;
          ew_raddr = in_idx;
        end else if (n_in == '0) state_nxt = S_CLR;
        else begin
          state_nxt = S_FRD;
          sc_we = 1'b1;
          sc_waddr = '0;
          sc_wdata = '0;
          pr_wdata = '0;
        end
      end
      S_ERD: state_nxt = S_EWR;
      S_EWR: begin
        ew_we = !ew_q[32] || ($signed(req_r.edge_weight) > $signed(ew_q[31:0]));
        state_nxt = S_IDLE;
      end
      S_FRD: begin
        ew_raddr = f_idx;
        sc_raddr = b_r;
        if (b_r >= n_r) state_nxt = S_BRD;
        else if (f_skip) state_nxt = S_FRD;
        else state_nxt = S_FCMP;
      end
      S_FCMP: begin
        sc_raddr = e_r;
        state_nxt = S_FWR;
      end
      S_FWR: begin
        sc_we = wv_r && (!reach_r[e_r] || ($signed(cand_r) > $signed(sc_q)) ||
                ((cand_r == sc_q) && (b_r < pr_q)));
        state_nxt = S_FRD;
      end
      S_BRD: begin
        sc_raddr = pos_r;
        if (pos_r == '0) state_nxt = S_ORD;
        else if (!reach_r[pos_r] || dep_r >= POSW'(MAX_CHARS)) begin
          out_v_nxt = 1'b1;
          state_nxt = S_CLR;
        end else state_nxt = S_BPUSH;
      end
      S_BPUSH: begin
        sc_raddr = pos_r;
        stk_we = 1'b1;
        state_nxt = S_BRD;
      end
      S_ORD: begin
        stk_addr = BW'(dep_r - k_r - 1'b1);
        state_nxt = (k_r >= dep_r) ? S_CLR : S_OBEG;
      end
      S_OBEG: begin
        sc_raddr = stk_q;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        sc_raddr = oend_r;
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt = 1'b1;
          state_nxt = S_ORD;
        end
      end
      S_CLR: begin
        ew_we = 1'b1;
        ew_waddr = clr_r;
        ew_wdata = '0;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      reach_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      case (state_r)
        S_IDLE: if (in_acc) begin
          req_r <= in_ch.data;
          idx_r <= in_idx;
          n_r   <= n_in;
          b_r   <= '0;
          s_r   <= 5'd1;
          dep_r <= '0;
          k_r   <= '0;
          reach_r <= {{MAX_CHARS{1'b0}}, (in_ch.data.req_type == REQ_SOLVE)};
        end
        S_FRD: begin
          e_r <= POSW'(e_calc);
          if (b_r >= n_r) begin
            pos_r <= n_r;
          end else if (f_skip) begin
            b_r <= b_r + 1'b1;
            s_r <= 5'd1;
          end
        end
        S_FCMP: begin
          cand_r <= sc_q + wsel;
          wv_r   <= (s_r == 5'd1) || ew_q[32];
        end
        S_FWR: begin
          if (sc_we) reach_r[e_r] <= 1'b1;
          s_r <= s_r + 5'd1;
        end
        S_BRD: if (pos_r != '0 && (!reach_r[pos_r] || dep_r >= POSW'(MAX_CHARS))) begin
          out_r <= '{seg_begin: '0, seg_end: '0, status: STATUS_DISC, last: 1'b1};
        end
        S_BPUSH: begin
          dep_r <= dep_r + 1'b1;
          pos_r <= pr_q;
        end
        S_OBEG: oend_r <= stk_q;
        S_OUT: if (!out_v_r || out_ch.ready) begin
          out_r <= '{seg_begin: 6'(pr_q), seg_end: 7'(oend_r),
                     status: STATUS_OK, last: (k_r + 1'b1 == dep_r)};
          k_r <= k_r + 1'b1;
        end
        S_CLR: clr_r <= (clr_r == AW'(DEPTH - 1)) ? '0 : clr_r + 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_start_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FCMP) |-> reach_r[0]) else $error("origin unreached");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r) else $error("result dropped");
`endif
endmodule
